// ===== hdl/psq_pkg.sv =====
// shared constants, types and the startup sort schedule for the p-square estimator
// no dependencies
package psq_pkg;

    localparam int SW    = 32;
    localparam int PW    = 32;
    localparam int DPW   = 49;
    localparam int CW    = 50;
    localparam int AW    = 68;
    localparam int BW    = 34;
    localparam int CNTW  = 7;
    localparam int NMK   = 5;
    localparam int QW    = 17;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [QW-1:0]      Q_ONE   = 17'h10000;
    localparam logic [QW-1:0]      Q_RESET = 17'h08000;
    localparam logic [PADDR_W-1:0] ADDR_TARGET_Q = 2'd0;
    localparam logic [PW-1:0]      POS_MAX = '1;
    localparam logic [2:0]         START_DONE = 3'd5;
    localparam logic [2:0]         START_LAST = 3'd4;
    localparam logic [2:0]         MK_FIRST = 3'd1;
    localparam logic [2:0]         MK_LAST  = 3'd3;
    localparam logic [3:0]         SORT_LAST = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SORT,
        S_UPDATE,
        S_MK_LOAD,
        S_MK_DECIDE,
        S_MUL1,
        S_DIV1,
        S_MUL2,
        S_DIV2,
        S_DIV3,
        S_CHECK,
        S_DIV4,
        S_EMIT
    } t_state;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

    // lower index of the compare-swap pair for each bubble sort step
    function automatic logic [2:0] sort_lo(input logic [3:0] step);
        logic [2:0] lo;
        case (step)
            4'd0:    lo = 3'd0;
            4'd1:    lo = 3'd1;
            4'd2:    lo = 3'd2;
            4'd3:    lo = 3'd3;
            4'd4:    lo = 3'd0;
            4'd5:    lo = 3'd1;
            4'd6:    lo = 3'd2;
            4'd7:    lo = 3'd0;
            4'd8:    lo = 3'd1;
            4'd9:    lo = 3'd0;
            default: lo = 3'd0;
        endcase
        return lo;
    endfunction

endpackage

// ===== hdl/psq_obs_if.sv =====
// observation channel: valid/ready handshake with one signed q16.16 word
// depends on psq_pkg
interface psq_obs_if import psq_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] observation;

    modport source (output valid, output observation, input ready);
    modport sink   (input valid, input observation, output ready);
endinterface

// ===== hdl/psq_res_if.sv =====
// result channel: valid/ready handshake with estimate and status flags
// depends on psq_pkg
interface psq_res_if import psq_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] estimate;
    logic                 ready_res;
    logic                 count_saturated;

    modport source (output valid, output estimate, output ready_res, output count_saturated,
                    input ready);
    modport sink   (input valid, input estimate, input ready_res, input count_saturated,
                    output ready);
endinterface

// ===== hdl/psq_mdu.sv =====
// shared sequential multiply / divide unit, signed dividend, unsigned divisor
// shift-add multiply one bit a cycle, restoring divide one bit a cycle; depends on psq_pkg
module psq_mdu import psq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mdu_req             i_req,
    input  logic signed [AW-1:0] i_a,
    input  logic [BW-1:0]        i_b,
    output logic                 o_done,
    output logic signed [AW-1:0] o_res
);

    logic            r_busy, n_busy;
    logic            r_fin, n_fin;
    t_mdu_op         r_op, n_op;
    logic            r_neg, n_neg;
    logic            r_zero, n_zero;
    logic [AW-1:0]   r_mag, n_mag;
    logic [BW-1:0]   r_b, n_b;
    logic [AW-1:0]   r_acc, n_acc;
    logic [BW:0]     r_rem, n_rem;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [BW:0]     rem_sh;
    logic            qbit;

    always_comb begin
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_op   = r_op;
        n_neg  = r_neg;
        n_zero = r_zero;
        n_mag  = r_mag;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        rem_sh = {r_rem[BW-1:0], r_mag[AW-1]};
        qbit   = rem_sh >= {1'b0, r_b};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_neg  = i_a[AW-1];
            n_mag  = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
            n_b    = i_b;
            n_acc  = '0;
            n_rem  = '0;
            n_zero = (i_req.op == OP_DIV) && (i_b == '0);
            n_cnt  = (i_req.op == OP_MUL) ? CNTW'(BW) : CNTW'(AW);
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_mag;
                end
                n_mag = r_mag << 1;
                n_b   = r_b >> 1;
            end else begin
                n_rem = qbit ? (rem_sh - {1'b0, r_b}) : rem_sh;
                n_acc = {r_acc[AW-2:0], qbit};
                n_mag = r_mag << 1;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_mag  <= n_mag;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
    end

    assign o_done = r_fin;
    assign o_res  = r_zero ? '0 : (r_neg ? -$signed(r_acc) : $signed(r_acc));

endmodule

// ===== hdl/p_square_quantile_estimator.sv =====
// top level of the five-marker p-square running quantile estimator
// depends on psq_pkg, psq_obs_if, psq_res_if and psq_mdu
//
// usage: observation words (signed q16.16) enter on i_obs, one result word per
// observation leaves on o_res with the middle marker height, a ready flag once
// five observations are sorted in, and a flag once marker positions saturate.
// target_quantile (q1.16, 65536 = 1.0) sits at apb address 0; write it while idle.
// one observation is in work at a time; i_obs.ready is low until its result is
// loaded into the output register and goes high in the cycle after that load.
// the first four observations are only stored, the fifth is then sorted in by a
// bubble sort (one compare-swap a cycle), and later ones are run through the shared
// multiply/divide unit: per inner marker two multiplies and up to four divides,
// three markers in turn. once saturated an observation skips the marker update.
// reset (synchronous, active low) clears the markers to their start values and
// sets the quantile to 0.5. a stalled receiver holds the result word in the
// output register; the next observation may be accepted meanwhile and its
// result waits until the register frees.
module p_square_quantile_estimator import psq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    psq_obs_if.sink            i_obs,
    psq_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_state               r_state, n_state;
    logic [QW-1:0]        r_q;
    logic signed [SW-1:0] r_x, n_x;
    logic [2:0]           r_scnt, n_scnt;
    logic [2:0]           r_mk, n_mk;
    logic [3:0]           r_step, n_step;
    logic signed [SW-1:0] r_h [NMK];
    logic signed [SW-1:0] n_h [NMK];
    logic [PW-1:0]        r_pos [NMK];
    logic [PW-1:0]        n_pos [NMK];
    logic [DPW-1:0]       r_dp [NMK];
    logic [DPW-1:0]       n_dp [NMK];
    logic signed [SW-1:0] r_hl, n_hl, r_hm, n_hm, r_hh, n_hh;
    logic [PW-1:0]        r_pm, n_pm, r_gb, n_gb, r_gc, n_gc;
    logic [DPW-1:0]       r_want, n_want;
    logic                 r_up, n_up;
    logic signed [AW-1:0] r_t, n_t;
    logic signed [AW-1:0] r_cand, n_cand;
    logic                 r_ov, n_ov;
    logic signed [SW-1:0] r_est, n_est;
    logic                 r_rdy, n_rdy;
    logic                 r_sat, n_sat;

    t_mdu_req             mdu_req;
    logic signed [AW-1:0] mdu_a;
    logic [BW-1:0]        mdu_b;
    logic                 mdu_done;
    logic signed [AW-1:0] mdu_res;

    logic [QW-1:0]        p;
    logic [DPW-1:0]       inc [NMK];
    logic [2:0]           lo;
    logic [2:0]           k;
    logic                 up_ok, dn_ok;
    logic signed [AW-1:0] hl_x, hm_x, hh_x, sum;
    logic                 fin;

    psq_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .i_a     (mdu_a),
        .i_b     (mdu_b),
        .o_done  (mdu_done),
        .o_res   (mdu_res)
    );

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TARGET_Q) ? PDATA_W'(r_q) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= Q_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_TARGET_Q) begin
            r_q <= pwdata[QW-1:0];
        end
    end

    assign p = (r_q > Q_ONE) ? Q_ONE : r_q;
    always_comb begin
        inc[0] = '0;
        inc[1] = DPW'(p >> 1);
        inc[2] = DPW'(p);
        inc[3] = DPW'(({1'b0, Q_ONE} + {1'b0, p}) >> 1);
        inc[4] = DPW'(Q_ONE);
    end

    assign hl_x  = {{(AW-SW){r_hl[SW-1]}}, r_hl};
    assign hm_x  = {{(AW-SW){r_hm[SW-1]}}, r_hm};
    assign hh_x  = {{(AW-SW){r_hh[SW-1]}}, r_hh};
    assign sum   = r_t + mdu_res;
    assign up_ok = (CW'(r_want) >= ((CW'(r_pm) + CW'(1)) << 16)) && (r_gb > PW'(1));
    assign dn_ok = (CW'(r_want) + CW'(Q_ONE) <= (CW'(r_pm) << 16)) && (r_gc > PW'(1));
    assign lo    = sort_lo(r_step);
    assign fin   = (r_scnt == START_DONE);

    assign i_obs.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ov;
    assign o_res.estimate    = r_est;
    assign o_res.ready_res   = r_rdy;
    assign o_res.count_saturated = r_sat;

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_scnt  = r_scnt;
        n_mk    = r_mk;
        n_step  = r_step;
        n_h     = r_h;
        n_pos   = r_pos;
        n_dp    = r_dp;
        n_hl    = r_hl;
        n_hm    = r_hm;
        n_hh    = r_hh;
        n_pm    = r_pm;
        n_gb    = r_gb;
        n_gc    = r_gc;
        n_want  = r_want;
        n_up    = r_up;
        n_t     = r_t;
        n_cand  = r_cand;
        n_ov    = r_ov && !o_res.ready;
        n_est   = r_est;
        n_rdy   = r_rdy;
        n_sat   = r_sat;
        mdu_req = '{start: 1'b0, op: OP_MUL};
        mdu_a   = '0;
        mdu_b   = '0;
        k       = 3'd3;
        case (r_state)
            S_IDLE: begin
                if (i_obs.valid) begin
                    n_x     = i_obs.observation;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!fin) begin
                    n_h[r_scnt] = r_x;
                    n_scnt      = r_scnt + 1'b1;
                    n_step      = '0;
                    n_state     = (r_scnt == START_LAST) ? S_SORT : S_EMIT;
                end else if (r_pos[4] < POS_MAX) begin
                    n_state = S_UPDATE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SORT: begin
                if (r_h[lo] > r_h[lo + 3'd1]) begin
                    n_h[lo]        = r_h[lo + 3'd1];
                    n_h[lo + 3'd1] = r_h[lo];
                end
                n_step = r_step + 1'b1;
                if (r_step == SORT_LAST) begin
                    n_dp[0] = '0;
                    n_dp[1] = DPW'(p) << 1;
                    n_dp[2] = DPW'(p) << 2;
                    n_dp[3] = (DPW'(Q_ONE) << 1) + (DPW'(p) << 1);
                    n_dp[4] = DPW'(Q_ONE) << 2;
                    n_state = S_EMIT;
                end
            end
            S_UPDATE: begin
                if (r_x < r_h[0]) begin
                    n_h[0] = r_x;
                    k      = 3'd0;
                end else if (r_x < r_h[1]) begin
                    k = 3'd0;
                end else if (r_x < r_h[2]) begin
                    k = 3'd1;
                end else if (r_x < r_h[3]) begin
                    k = 3'd2;
                end else begin
                    k = 3'd3;
                    if (r_x > r_h[4]) begin
                        n_h[4] = r_x;
                    end
                end
                for (int i = 1; i < NMK; i++) begin
                    if (3'(i) > k) begin
                        n_pos[i] = r_pos[i] + 1'b1;
                    end
                end
                for (int i = 0; i < NMK; i++) begin
                    n_dp[i] = r_dp[i] + inc[i];
                end
                n_mk    = MK_FIRST;
                n_state = S_MK_LOAD;
            end
            S_MK_LOAD: begin
                n_hl    = r_h[r_mk - 3'd1];
                n_hm    = r_h[r_mk];
                n_hh    = r_h[r_mk + 3'd1];
                n_pm    = r_pos[r_mk];
                n_gb    = r_pos[r_mk + 3'd1] - r_pos[r_mk];
                n_gc    = r_pos[r_mk] - r_pos[r_mk - 3'd1];
                n_want  = r_dp[r_mk];
                n_state = S_MK_DECIDE;
            end
            S_MK_DECIDE: begin
                if (up_ok || dn_ok) begin
                    n_up    = up_ok;
                    mdu_req = '{start: 1'b1, op: OP_MUL};
                    mdu_a   = hh_x - hm_x;
                    mdu_b   = up_ok ? (BW'(r_gc) + BW'(1)) : (BW'(r_gc) - BW'(1));
                    n_state = S_MUL1;
                end else begin
                    n_mk    = r_mk + 3'd1;
                    n_state = (r_mk == MK_LAST) ? S_EMIT : S_MK_LOAD;
                end
            end
            S_MUL1: begin
                if (mdu_done) begin
                    mdu_req = '{start: 1'b1, op: OP_DIV};
                    mdu_a   = mdu_res;
                    mdu_b   = BW'(r_gb);
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                if (mdu_done) begin
                    n_t     = mdu_res;
                    mdu_req = '{start: 1'b1, op: OP_MUL};
                    mdu_a   = hm_x - hl_x;
                    mdu_b   = r_up ? (BW'(r_gb) - BW'(1)) : (BW'(r_gb) + BW'(1));
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                if (mdu_done) begin
                    mdu_req = '{start: 1'b1, op: OP_DIV};
                    mdu_a   = mdu_res;
                    mdu_b   = BW'(r_gc);
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (mdu_done) begin
                    mdu_req = '{start: 1'b1, op: OP_DIV};
                    mdu_a   = r_up ? sum : -sum;
                    mdu_b   = BW'(r_gb) + BW'(r_gc);
                    n_state = S_DIV3;
                end
            end
            S_DIV3: begin
                if (mdu_done) begin
                    n_cand  = hm_x + mdu_res;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (hl_x < r_cand && r_cand < hh_x) begin
                    n_h[r_mk]   = r_cand[SW-1:0];
                    n_pos[r_mk] = r_up ? (r_pm + 1'b1) : (r_pm - 1'b1);
                    n_mk        = r_mk + 3'd1;
                    n_state     = (r_mk == MK_LAST) ? S_EMIT : S_MK_LOAD;
                end else begin
                    mdu_req = '{start: 1'b1, op: OP_DIV};
                    mdu_a   = (r_up ? hh_x : hl_x) - hm_x;
                    mdu_b   = r_up ? BW'(r_gb) : BW'(r_gc);
                    n_state = S_DIV4;
                end
            end
            S_DIV4: begin
                if (mdu_done) begin
                    n_h[r_mk]   = r_hm + mdu_res[SW-1:0];
                    n_pos[r_mk] = r_up ? (r_pm + 1'b1) : (r_pm - 1'b1);
                    n_mk        = r_mk + 3'd1;
                    n_state     = (r_mk == MK_LAST) ? S_EMIT : S_MK_LOAD;
                end
            end
            S_EMIT: begin
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_est   = fin ? r_h[2] : '0;
                    n_rdy   = fin;
                    n_sat   = fin && (r_pos[4] == POS_MAX);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scnt  <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < NMK; i++) begin
                r_h[i]   <= '0;
                r_pos[i] <= PW'(i);
                r_dp[i]  <= DPW'(i) << 16;
            end
        end else begin
            r_state <= n_state;
            r_scnt  <= n_scnt;
            r_ov    <= n_ov;
            r_h     <= n_h;
            r_pos   <= n_pos;
            r_dp    <= n_dp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_mk   <= n_mk;
        r_step <= n_step;
        r_hl   <= n_hl;
        r_hm   <= n_hm;
        r_hh   <= n_hh;
        r_pm   <= n_pm;
        r_gb   <= n_gb;
        r_gc   <= n_gc;
        r_want <= n_want;
        r_up   <= n_up;
        r_t    <= n_t;
        r_cand <= n_cand;
        r_est  <= n_est;
        r_rdy  <= n_rdy;
        r_sat  <= n_sat;
    end

endmodule
